/* hw/rtl/ste_pkg.sv */
// Shared types, constants and the coordinate fold function for the sprite
// entry tile expander. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ste_pkg;

   localparam int unsigned WordWidth  = 16;
   localparam int unsigned PrioWidth  = 2;
   localparam int unsigned CodeWidth  = 14;
   localparam int unsigned ColorWidth = 6;
   localparam int unsigned PosWidth   = 17;
   localparam int unsigned CountWidth = 3;

   localparam logic [15:0] XBias     = 16'd128;
   localparam logic [16:0] TileStep  = 17'd16;
   localparam int unsigned EnableBit = 15;
   localparam int unsigned FlipBit   = 6;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } ste_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic advance;
   } ste_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic keep;
      logic last;
   } ste_status_type;

   // A coordinate with bit 15 set becomes its low nine bits minus 512.
   function automatic logic signed [PosWidth-1:0] fold_coord(input logic [WordWidth-1:0] v);
      logic signed [PosWidth-1:0] res;
      if (v[15]) begin
         res = {7'h7f, 1'b1, v[8:0]};
      end else begin
         res = {1'b0, v};
      end
      return res;
   endfunction

endpackage

/* hw/rtl/sprite_entry_tile_expander_top.sv */
// Top level of the sprite entry tile expander: joins the controller and
// the datapath. Depends on ste_pkg, ste_ctrl and ste_datapath.
//
//   Channel | Direction | Handshake             | Contents
//   --------+-----------+-----------------------+-----------------------------------
//   req_    | in        | req_valid / req_stall | one sprite entry and pass priority
//   rsp_    | out       | rsp_valid / rsp_stall | one 16x16 tile command
//
// A request is taken while the controller is idle. An entry that is disabled or
// belongs to another pass is dropped as it is taken, and the next request may
// follow at once. A kept entry gives width times height tile commands, one per
// cycle while the result side does not stall; the tile counters in the datapath
// step through them. Reset is synchronous and active high and clears only the
// controller state. A stall on the result side holds the current tile command
// unchanged, and req_stall stays high until the last tile of the entry has been
// taken.
`timescale 1ns / 1ps

module sprite_entry_tile_expander_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [ste_pkg::WordWidth-1:0]           req_attr_word,
   input  logic [ste_pkg::WordWidth-1:0]           req_code_word,
   input  logic [ste_pkg::WordWidth-1:0]           req_x_word,
   input  logic [ste_pkg::WordWidth-1:0]           req_y_word,
   input  logic [ste_pkg::PrioWidth-1:0]           req_pass_priority,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [ste_pkg::CodeWidth-1:0]           rsp_tile_code,
   output logic [ste_pkg::ColorWidth-1:0]          rsp_tile_color,
   output logic                                    rsp_flip_x,
   output logic signed [ste_pkg::PosWidth-1:0]     rsp_pos_x,
   output logic signed [ste_pkg::PosWidth-1:0]     rsp_pos_y,
   output logic                                    rsp_last_tile
);
   import ste_pkg::*;

   // Commands flow from the controller into the datapath; the datapath
   // reports whether a request is kept and when the last tile is showing.
   ste_cmd_type    cmd;
   ste_status_type status;

   ste_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ste_datapath u_datapath (
      .clock             (clock),
      .req_attr_word     (req_attr_word),
      .req_code_word     (req_code_word),
      .req_x_word        (req_x_word),
      .req_y_word        (req_y_word),
      .req_pass_priority (req_pass_priority),
      .cmd               (cmd),
      .status            (status),
      .rsp_tile_code     (rsp_tile_code),
      .rsp_tile_color    (rsp_tile_color),
      .rsp_flip_x        (rsp_flip_x),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_last_tile     (rsp_last_tile)
   );

endmodule

/* hw/rtl/ste_ctrl.sv */
// Controller state machine of the sprite entry tile expander.
// Depends on ste_pkg for the state, command and status types.
`timescale 1ns / 1ps

module ste_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  ste_pkg::ste_status_type status,
   output ste_pkg::ste_cmd_type    cmd
);
   import ste_pkg::*;

   ste_state_type state_ff;
   ste_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.keep) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/ste_datapath.sv */
// Datapath of the sprite entry tile expander: entry decode, tile counters
// and the registered tile command. Depends on ste_pkg.
`timescale 1ns / 1ps

module ste_datapath (
   input  logic                                    clock,
   input  logic [ste_pkg::WordWidth-1:0]           req_attr_word,
   input  logic [ste_pkg::WordWidth-1:0]           req_code_word,
   input  logic [ste_pkg::WordWidth-1:0]           req_x_word,
   input  logic [ste_pkg::WordWidth-1:0]           req_y_word,
   input  logic [ste_pkg::PrioWidth-1:0]           req_pass_priority,
   input  ste_pkg::ste_cmd_type                    cmd,
   output ste_pkg::ste_status_type                 status,
   output logic [ste_pkg::CodeWidth-1:0]           rsp_tile_code,
   output logic [ste_pkg::ColorWidth-1:0]          rsp_tile_color,
   output logic                                    rsp_flip_x,
   output logic signed [ste_pkg::PosWidth-1:0]     rsp_pos_x,
   output logic signed [ste_pkg::PosWidth-1:0]     rsp_pos_y,
   output logic                                    rsp_last_tile
);
   import ste_pkg::*;

   logic [CodeWidth-1:0]         tile_ff;
   logic [ColorWidth-1:0]        color_ff;
   logic                         flip_ff;
   logic [CountWidth-1:0]        wm1_ff;
   logic [CountWidth-1:0]        hm1_ff;
   logic [CountWidth-1:0]        col_ff;
   logic [CountWidth-1:0]        row_ff;
   logic signed [PosWidth-1:0]   ybase_ff;
   logic signed [PosWidth-1:0]   px_ff;
   logic signed [PosWidth-1:0]   py_ff;

   logic [WordWidth-1:0]         x_biased;
   logic signed [PosWidth-1:0]   x_fold;
   logic [CountWidth-1:0]        wm1_dec;
   logic signed [PosWidth-1:0]   x_first;

   assign x_biased = req_x_word + XBias;
   assign x_fold   = fold_coord(x_biased);
   assign wm1_dec  = req_attr_word[12:10];
   // A mirrored entry starts at its rightmost column.
   assign x_first  = req_attr_word[FlipBit] ? x_fold + {10'd0, wm1_dec, 4'd0} : x_fold;

   assign status.keep = req_attr_word[EnableBit] &&
                        (req_code_word[15:14] == req_pass_priority);
   assign status.last = (col_ff == wm1_ff) && (row_ff == hm1_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tile_ff  <= {1'b0, req_code_word[12:0]};
         color_ff <= req_attr_word[5:0];
         flip_ff  <= req_attr_word[FlipBit];
         wm1_ff   <= wm1_dec;
         hm1_ff   <= req_attr_word[9:7];
         col_ff   <= '0;
         row_ff   <= '0;
         ybase_ff <= fold_coord(req_y_word);
         py_ff    <= fold_coord(req_y_word);
         px_ff    <= x_first;
      end else if (cmd.advance) begin
         tile_ff <= tile_ff + 1'b1;
         if (row_ff == hm1_ff) begin
            row_ff <= '0;
            col_ff <= col_ff + 1'b1;
            py_ff  <= ybase_ff;
            px_ff  <= flip_ff ? px_ff - TileStep : px_ff + TileStep;
         end else begin
            row_ff <= row_ff + 1'b1;
            py_ff  <= py_ff + TileStep;
         end
      end
   end

   assign rsp_tile_code  = tile_ff;
   assign rsp_tile_color = color_ff;
   assign rsp_flip_x     = flip_ff;
   assign rsp_pos_x      = px_ff;
   assign rsp_pos_y      = py_ff;
   assign rsp_last_tile  = status.last;

endmodule

/* test/sprite_entry_tile_expander_top_tb.sv */
// Self-checking testbench for sprite_entry_tile_expander_top. It drives sprite
// list entries and checks every tile command against its own expansion of the
// entry. Depends on ste_pkg and the block's RTL only.
`timescale 1ns / 1ps

module sprite_entry_tile_expander_top_tb;

   // Bounds used to size the timeout. The slowest correct run has every entry
   // wait out the longest sender gap and expand to the largest sprite, and
   // every tile wait out the longest receiver stall. Ignored entries are
   // counted too, so the entry figure is well above the number actually sent.
   localparam int MaxTiles   = 64;
   localparam int MaxStall   = 30;
   localparam int MaxGap     = 30;
   localparam int MaxEntries = 1200;
   localparam int HoldCycles = 400;
   localparam int CycleLimit =
      2 * MaxEntries * (MaxGap + 1 + MaxTiles * (MaxStall + 1)) + HoldCycles;

   // A kept entry gives at most 64 tile commands.
   localparam int SettleCycles = 80;
   localparam int MaxReports   = 10;

   // The fold turns a coordinate with bit 15 set into its low nine bits
   // minus this span.
   localparam logic [16:0] FoldSpan = 17'd512;

   // One tile command as the block presents it on the result channel.
   typedef struct packed {
      logic [ste_pkg::CodeWidth-1:0]         code;
      logic [ste_pkg::ColorWidth-1:0]        color;
      logic                                  flip;
      logic signed [ste_pkg::PosWidth-1:0]   px;
      logic signed [ste_pkg::PosWidth-1:0]   py;
      logic                                  last;
   } tile_cmd_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [ste_pkg::WordWidth-1:0]         req_attr_word;
   logic [ste_pkg::WordWidth-1:0]         req_code_word;
   logic [ste_pkg::WordWidth-1:0]         req_x_word;
   logic [ste_pkg::WordWidth-1:0]         req_y_word;
   logic [ste_pkg::PrioWidth-1:0]         req_pass_priority;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic [ste_pkg::CodeWidth-1:0]         rsp_tile_code;
   logic [ste_pkg::ColorWidth-1:0]        rsp_tile_color;
   logic                                  rsp_flip_x;
   logic signed [ste_pkg::PosWidth-1:0]   rsp_pos_x;
   logic signed [ste_pkg::PosWidth-1:0]   rsp_pos_y;
   logic                                  rsp_last_tile;

   // Tile commands predicted for accepted requests, oldest first.
   tile_cmd_type expected_tiles[$];

   int fail_count       = 0;
   int cycle_count      = 0;
   int long_hold_cycles = 0;
   bit tx_idle_on       = 1'b0;
   bit rsp_idle_on      = 1'b0;

   sprite_entry_tile_expander_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_attr_word     (req_attr_word),
      .req_code_word     (req_code_word),
      .req_x_word        (req_x_word),
      .req_y_word        (req_y_word),
      .req_pass_priority (req_pass_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tile_code     (rsp_tile_code),
      .rsp_tile_color    (rsp_tile_color),
      .rsp_flip_x        (rsp_flip_x),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_last_tile     (rsp_last_tile)
   );

   always #6 clock = ~clock;

   // Idle stretches are mostly short, with the odd long one.
   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, MaxStall);
      end
      return $urandom_range(1, 3);
   endfunction

   // Coordinates with bit 15 set wrap round to -512..-1.
   function automatic logic signed [16:0] fold_position(input logic [15:0] v);
      if (v[15]) begin
         return {8'b0, v[8:0]} - FoldSpan;
      end
      return {1'b0, v};
   endfunction

   // Works out the tile commands that one sprite entry gives for the current
   // pass and queues them. Columns are the outer loop and rows the inner one;
   // the tile number counts up by one per command and the column offset is
   // mirrored when the sprite is flipped. Returns the number of tiles.
   function automatic int expand_entry(input logic [15:0] attr, input logic [15:0] code,
                                       input logic [15:0] xw, input logic [15:0] yw,
                                       input logic [1:0] pass);
      logic [15:0]        biased_x;
      logic signed [16:0] left, top;
      logic [13:0]        next_code;
      int                 w, h, cpos;
      tile_cmd_type       cmd;
      if (!attr[ste_pkg::EnableBit] || code[15:14] != pass) begin
         return 0;
      end
      biased_x  = xw + ste_pkg::XBias;
      left      = fold_position(biased_x);
      top       = fold_position(yw);
      next_code = {1'b0, code[12:0]};
      h         = int'(attr[9:7]) + 1;
      w         = int'(attr[12:10]) + 1;
      for (int col = 0; col < w; col++) begin
         for (int row = 0; row < h; row++) begin
            cpos      = attr[ste_pkg::FlipBit] ? (w - 1 - col) : col;
            cmd.code  = next_code;
            cmd.color = attr[5:0];
            cmd.flip  = attr[ste_pkg::FlipBit];
            cmd.px    = left + 17'(cpos * 16);
            cmd.py    = top + 17'(row * 16);
            cmd.last  = (col == w - 1) && (row == h - 1);
            expected_tiles.push_back(cmd);
            next_code = next_code + 14'd1;
         end
      end
      return w * h;
   endfunction

   function automatic logic [15:0] make_attr(input bit en, input int w, input int h,
                                             input bit flip, input int color);
      return {en, 2'b00, 3'(w - 1), 3'(h - 1), flip, 6'(color)};
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MaxReports) begin
         $display("%s", msg);
      end
   endtask

   // Offers one request and holds it until the block takes it. When the
   // sender is allowed to idle, valid may drop for a while beforehand;
   // otherwise valid stays high from one request to the next.
   task automatic send_entry(input logic [15:0] attr, input logic [15:0] code,
                             input logic [15:0] xw, input logic [15:0] yw,
                             input logic [1:0] pass, output int tiles);
      int gap;
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         gap = idle_length();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_attr_word     <= attr;
      req_code_word     <= code;
      req_x_word        <= xw;
      req_y_word        <= yw;
      req_pass_priority <= pass;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tiles = expand_entry(attr, code, xw, yw, pass);
   endtask

   // Positions near the bias wrap and the fold threshold, near zero, or
   // anything at all.
   function automatic logic [15:0] pick_x();
      case ($urandom_range(0, 5))
         0: return {($urandom_range(0, 1) ? 8'hFF : 8'h7F), 8'($urandom)};
         1: return {7'b0, 9'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_y();
      case ($urandom_range(0, 5))
         0: return {($urandom_range(0, 1) ? 8'h80 : 8'h7F), 8'($urandom)};
         1: return {7'b0, 9'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   // Builds one random request. Most are enabled entries for the current
   // pass with small sprites; some belong to another pass and some are pure
   // noise. With full_size set the sprite is always eight by eight.
   task automatic random_entry(input bit full_size, output logic [15:0] attr,
                               output logic [15:0] code, output logic [15:0] xw,
                               output logic [15:0] yw, output logic [1:0] pass);
      int kind, w, h;
      kind = full_size ? 0 : $urandom_range(0, 9);
      pass = 2'($urandom);
      xw   = pick_x();
      yw   = pick_y();
      if (kind >= 8) begin
         attr = 16'($urandom);
         code = 16'($urandom);
      end else begin
         w    = full_size ? 8 : (($urandom_range(0, 11) == 0) ? $urandom_range(1, 8)
                                                               : $urandom_range(1, 3));
         h    = full_size ? 8 : (($urandom_range(0, 11) == 0) ? $urandom_range(1, 8)
                                                               : $urandom_range(1, 3));
         attr = make_attr(1'b1, w, h, 1'($urandom), $urandom_range(0, 63));
         attr[14:13] = 2'($urandom);
         code = 16'($urandom);
         // A broken entry carries a priority one above that of the pass.
         code[15:14] = (kind == 7) ? pass + 2'd1 : pass;
      end
   endtask

   // Lowers valid and waits until every predicted tile has been seen.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_tiles.size() != 0) @(posedge clock);
   endtask

   // Sends random requests until the given number of them have been kept.
   task automatic random_burst(input int kept_target);
      logic [15:0] attr, code, xw, yw;
      logic [1:0]  pass;
      int          tiles, kept;
      kept = 0;
      while (kept < kept_target) begin
         random_entry(1'b0, attr, code, xw, yw, pass);
         send_entry(attr, code, xw, yw, pass, tiles);
         if (tiles != 0) kept++;
      end
   endtask

   // Corner cases: the smallest and largest sprites and tile numbers, the
   // bias wrap at the top of the X range, both sides of the fold threshold,
   // disabled entries, entries from another pass, every pass priority, and
   // the unused bits of the attribute and code words.
   task automatic test_directed_corners();
      int tiles;
      tx_idle_on  = 1'b0;
      rsp_idle_on = 1'b0;
      send_entry(make_attr(1, 1, 1, 0, 0), 16'h0000, 16'h0000, 16'h0000, 2'd0, tiles);
      send_entry(make_attr(1, 8, 8, 1, 63), {2'd3, 1'b0, 13'h1FFF},
                 16'hFFFF, 16'h7FFF, 2'd3, tiles);
      send_entry(make_attr(1, 8, 1, 1, 21), {2'd1, 1'b0, 13'h0ABC},
                 16'hFF80, 16'h8000, 2'd1, tiles);
      send_entry(make_attr(1, 1, 8, 0, 42), {2'd2, 1'b0, 13'h1555},
                 16'h7F80, 16'hFFFF, 2'd2, tiles);
      send_entry(make_attr(1, 8, 8, 0, 7), {2'd0, 1'b0, 13'h0100},
                 16'h7F7F, 16'h7FFF, 2'd0, tiles);
      send_entry(make_attr(1, 2, 3, 1, 33), {2'd1, 1'b0, 13'h1FFE},
                 16'hFF7F, 16'h81FF, 2'd1, tiles);
      // Disabled: every other attribute bit set, priority matching.
      send_entry(16'h7FFF, {2'd2, 1'b1, 13'h1FFF}, 16'h1234, 16'h0042, 2'd2, tiles);
      send_entry(16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0, tiles);
      // Enabled but belonging to another pass.
      send_entry(make_attr(1, 4, 4, 0, 9), {2'd2, 1'b0, 13'h0010},
                 16'h0100, 16'h0080, 2'd1, tiles);
      send_entry(make_attr(1, 1, 1, 1, 1), {2'd0, 1'b0, 13'h0001},
                 16'h0000, 16'h0000, 2'd3, tiles);
      // Unused attribute and code bits set; they must make no difference.
      send_entry(make_attr(1, 2, 2, 1, 55) | 16'h6000, {2'd3, 1'b1, 13'h0777},
                 16'h00F0, 16'h00A0, 2'd3, tiles);
      for (int p = 0; p < 4; p++) begin
         send_entry(make_attr(1, 2, 1, p[0], 10 + p), {2'(p), 1'b0, 13'($urandom)},
                    pick_x(), pick_y(), 2'(p), tiles);
      end
   endtask

   // The bulk of the traffic, with both sides idling at random.
   task automatic test_random_traffic();
      tx_idle_on  = 1'b1;
      rsp_idle_on = 1'b1;
      random_burst(190);
   endtask

   // Back-to-back requests and a result side that never stalls.
   task automatic test_no_idle();
      tx_idle_on  = 1'b0;
      rsp_idle_on = 1'b0;
      random_burst(80);
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering full-size sprites, so the block stalls its input side.
   task automatic test_backpressure();
      logic [15:0] attr, code, xw, yw;
      logic [1:0]  pass;
      int          tiles;
      tx_idle_on       = 1'b0;
      rsp_idle_on      = 1'b0;
      long_hold_cycles = HoldCycles;
      for (int i = 0; i < 6; i++) begin
         random_entry(1'b1, attr, code, xw, yw, pass);
         send_entry(attr, code, xw, yw, pass, tiles);
      end
   endtask

   // Two bursts with a full drain between them, so the block goes idle.
   task automatic test_pause_until_drained();
      tx_idle_on  = 1'b1;
      rsp_idle_on = 1'b1;
      random_burst(40);
      wait_drained();
      random_burst(40);
   endtask

   // Result-side stall. Each pass round the loop drives rsp_stall once and
   // then waits on the clock. A requested long hold-off takes priority and
   // is counted out here; otherwise stalls of random length come now and
   // then when idling is allowed.
   initial begin
      forever begin
         if (long_hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (long_hold_cycles) @(posedge clock);
            long_hold_cycles = 0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (idle_length()) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Every tile command taken from the block is compared with the oldest
   // prediction. Values are read at the edge, before the nonblocking updates
   // land, so they are the ones the handshake saw.
   always @(posedge clock) begin : check_tiles
      tile_cmd_type want, seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.code  = rsp_tile_code;
         seen.color = rsp_tile_color;
         seen.flip  = rsp_flip_x;
         seen.px    = rsp_pos_x;
         seen.py    = rsp_pos_y;
         seen.last  = rsp_last_tile;
         if (expected_tiles.size() == 0) begin
            note_failure($sformatf("unexpected tile command: code %0d x %0d y %0d",
                                   seen.code, $signed(seen.px), $signed(seen.py)));
         end else begin
            want = expected_tiles.pop_front();
            if (seen.code !== want.code || seen.color !== want.color ||
                seen.flip !== want.flip || seen.px !== want.px ||
                seen.py !== want.py || seen.last !== want.last) begin
               note_failure($sformatf(
                  {"tile mismatch: expected code %0d colour %0d flip %0b x %0d y %0d ",
                   "last %0b, got code %0d colour %0d flip %0b x %0d y %0d last %0b"},
                  want.code, want.color, want.flip, $signed(want.px), $signed(want.py),
                  want.last, seen.code, seen.color, seen.flip, $signed(seen.px),
                  $signed(seen.py), seen.last));
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Reset once, run each test in turn, then let the block settle so that
   // any stray tile command still shows up before the verdict.
   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_attr_word     <= '0;
      req_code_word     <= '0;
      req_x_word        <= '0;
      req_y_word        <= '0;
      req_pass_priority <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_traffic();
      test_no_idle();
      test_backpressure();
      test_pause_until_drained();

      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0 && expected_tiles.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
